// ===== src/lag_pkg.sv =====
// ----------------------------------------------------------------------------
// lag_pkg
// shared types, op codes and the b3/s23 cell rule for the life generation unit
// ----------------------------------------------------------------------------
package lag_pkg;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam int unsigned FIELD_W = 6;

    typedef struct packed {
        logic [1:0]         op;
        logic [FIELD_W-1:0] col;
        logic [FIELD_W-1:0] row;
        logic               cell_in;
    } t_cmd;

    typedef struct packed {
        logic alive;
        logic done_res;
    } t_res;

    // next state of one cell from its own value and its eight neighbours
    function automatic logic f_next_cell(input logic live, input logic [7:0] nb);
        logic [3:0] cnt;
        cnt = 4'd0;
        for (int i = 0; i < 8; i++) begin
            cnt = cnt + {3'd0, nb[i]};
        end
        return (cnt == 4'd3) || (live && (cnt == 4'd2));
    endfunction

endpackage

// ===== src/lag_row_ram.sv =====
// ----------------------------------------------------------------------------
// lag_row_ram
// row-wide grid memory, one write and one read port, registered read data
// ----------------------------------------------------------------------------
module lag_row_ram #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/lag_row_rule.sv =====
// ----------------------------------------------------------------------------
// lag_row_rule
// new generation of one row from the rows above, at and below it
// ----------------------------------------------------------------------------
module lag_row_rule #(
    parameter int GRID_WIDTH = 64
) (
    input  logic [GRID_WIDTH-1:0] i_up,
    input  logic [GRID_WIDTH-1:0] i_mid,
    input  logic [GRID_WIDTH-1:0] i_down,
    output logic [GRID_WIDTH-1:0] o_next
);

    for (genvar x = 0; x < GRID_WIDTH; x++) begin : g_lane
        // columns wrap around at both edges
        localparam int XM = (x + GRID_WIDTH - 1) % GRID_WIDTH;
        localparam int XP = (x + 1) % GRID_WIDTH;

        logic [7:0] nb;

        assign nb = {i_up[XM], i_up[x], i_up[XP],
                     i_mid[XM], i_mid[XP],
                     i_down[XM], i_down[x], i_down[XP]};
        assign o_next[x] = lag_pkg::f_next_cell(i_mid[x], nb);
    end

endmodule

// ===== src/life_automaton_generation_unit.sv =====
// ----------------------------------------------------------------------------
// life_automaton_generation_unit
// toroidal b3/s23 life grid in two ping-pong row memories
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                 payload
// -------   ---------  ------------------------  -------------------------
// command   in         start & !busy             i_cmd (op, col, row, cell_in)
// result    out        o_valid, one-cycle pulse  o_res (alive, done_res)
//
// access: a cell write or read first reads the row, then writes the row back
//   or selects the bit; a generation step streams every row once through the
//   single read port plus the two wrap rows, and ends when the last row is back
// reset: after i_rst_n the active bank is swept to dead, one row a cycle,
//   and busy stays high until the sweep is done
// stalls: the receiver cannot stall; each result is shown for exactly one cycle,
//   and busy is already low in that cycle so the next transfer can start
//
// each memory entry is one full row of GRID_WIDTH cells; a generation reads the
// active bank in order row H-1, 0, 1, ..., H-1, 0 and keeps a three-row window,
// writing each new row to the other bank, which then becomes the active one
// ----------------------------------------------------------------------------
module life_automaton_generation_unit #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  lag_pkg::t_cmd i_cmd,
    output logic          o_valid,
    output lag_pkg::t_res o_res
);

    localparam int CW = $clog2(GRID_WIDTH);
    localparam int RW = $clog2(GRID_HEIGHT);
    localparam int KW = $clog2(GRID_HEIGHT + 3);

    localparam logic [KW-1:0] K_LAST_ROW = KW'(GRID_HEIGHT - 1);
    localparam logic [KW-1:0] K_END      = KW'(GRID_HEIGHT + 1);
    localparam logic [KW-1:0] K_STOP     = KW'(GRID_HEIGHT + 2);
    localparam logic [RW-1:0] R_LAST     = RW'(GRID_HEIGHT - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_ACCESS,
        S_STEP
    } t_state;

    t_state             r_state;
    logic [KW-1:0]      r_k;        // clear row / step read index
    logic               r_dv;       // step read data arrives this cycle
    logic [KW-1:0]      r_dk;       // index of the arriving step row
    logic               r_sel;      // active bank
    logic               r_valid;
    lag_pkg::t_res      r_res;
    lag_pkg::t_cmd      r_cmd;
    logic [GRID_WIDTH-1:0] r_up;
    logic [GRID_WIDTH-1:0] r_mid;

    // memory controls
    logic                  we;
    logic                  wbank;
    logic [RW-1:0]         waddr;
    logic [GRID_WIDTH-1:0] wdata;
    logic [RW-1:0]         raddr;
    logic [GRID_WIDTH-1:0] rdata0;
    logic [GRID_WIDTH-1:0] rdata1;
    logic [GRID_WIDTH-1:0] rdata;
    logic [GRID_WIDTH-1:0] next_row;
    logic [GRID_WIDTH-1:0] mod_row;

    logic          accept;
    logic [31:0]   in_row32;
    logic [31:0]   cmd_col32;
    logic [31:0]   cmd_row32;
    logic [CW-1:0] col_idx;
    logic          in_grid;
    logic [RW-1:0] step_raddr;

    assign accept    = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign in_row32  = 32'(i_cmd.row);
    assign cmd_col32 = 32'(r_cmd.col);
    assign cmd_row32 = 32'(r_cmd.row);
    assign col_idx   = cmd_col32[CW-1:0];
    assign in_grid   = (cmd_col32 < 32'(GRID_WIDTH)) && (cmd_row32 < 32'(GRID_HEIGHT));
    assign rdata     = r_sel ? rdata1 : rdata0;

    // step read order wraps: last row first, then every row, then row 0 again
    always_comb begin
        if (r_k == '0) begin
            step_raddr = R_LAST;
        end else if (r_k == K_END) begin
            step_raddr = '0;
        end else begin
            step_raddr = RW'(r_k - KW'(1));
        end
    end

    always_comb begin
        mod_row          = rdata;
        mod_row[col_idx] = r_cmd.cell_in;
    end

    always_comb begin
        raddr = (r_state == S_IDLE) ? in_row32[RW-1:0] : step_raddr;
        we    = 1'b0;
        wbank = r_sel;
        waddr = '0;
        wdata = '0;
        case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                waddr = r_k[RW-1:0];
            end
            S_ACCESS: begin
                we    = (r_cmd.op == lag_pkg::OP_WRITE) && in_grid;
                waddr = cmd_row32[RW-1:0];
                wdata = mod_row;
            end
            S_STEP: begin
                // center row is two behind the arriving one
                we    = r_dv && (r_dk >= KW'(2));
                wbank = !r_sel;
                waddr = RW'(r_dk - KW'(2));
                wdata = next_row;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    lag_row_rule #(
        .GRID_WIDTH(GRID_WIDTH)
    ) u_rule (
        .i_up   (r_up),
        .i_mid  (r_mid),
        .i_down (rdata),
        .o_next (next_row)
    );

    lag_row_ram #(
        .DEPTH (GRID_HEIGHT),
        .DATA_W(GRID_WIDTH)
    ) u_bank0 (
        .i_clk  (i_clk),
        .i_we   (we && !wbank),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata0)
    );

    lag_row_ram #(
        .DEPTH (GRID_HEIGHT),
        .DATA_W(GRID_WIDTH)
    ) u_bank1 (
        .i_clk  (i_clk),
        .i_we   (we && wbank),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_k     <= '0;
            r_dv    <= 1'b0;
            r_dk    <= '0;
            r_sel   <= 1'b0;
            r_valid <= 1'b0;
            r_res   <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_k <= r_k + KW'(1);
                    if (r_k == K_LAST_ROW) begin
                        r_k     <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_cmd <= i_cmd;
                        r_k   <= '0;
                        r_dv  <= 1'b0;
                        r_state <= (i_cmd.op == lag_pkg::OP_STEP) ? S_STEP : S_ACCESS;
                    end
                end
                S_ACCESS: begin
                    r_res.alive    <= (r_cmd.op == lag_pkg::OP_READ) && in_grid
                                      && rdata[col_idx];
                    r_res.done_res <= 1'b0;
                    r_valid        <= 1'b1;
                    r_state        <= S_IDLE;
                end
                S_STEP: begin
                    // issue side
                    r_dv <= (r_k != K_STOP);
                    r_dk <= r_k;
                    if (r_k != K_STOP) begin
                        r_k <= r_k + KW'(1);
                    end
                    // arrival side: slide the three-row window
                    if (r_dv) begin
                        r_up  <= r_mid;
                        r_mid <= rdata;
                        if (r_dk == K_END) begin
                            r_sel          <= !r_sel;
                            r_dv           <= 1'b0;
                            r_k            <= '0;
                            r_res.alive    <= 1'b0;
                            r_res.done_res <= 1'b1;
                            r_valid        <= 1'b1;
                            r_state        <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== src/lag_checker.sv =====
// ----------------------------------------------------------------------------
// lag_checker
// port-level checks on command and result timing of the life generation unit
// ----------------------------------------------------------------------------
module lag_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input lag_pkg::t_cmd i_cmd,
    input logic          o_valid,
    input lag_pkg::t_res o_res
);

    // a transfer always occupies the unit
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("unit not busy after command transfer");

    // cell reads, writes and unused ops each answer with a result after their access state
    a_access_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.op != lag_pkg::OP_STEP) |-> ##2 o_valid)
        else $error("cell access result missing");

    // results never come back to back
    a_single_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // the unit is free again in the result cycle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    // a step result never carries a cell value
    a_done_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_res.alive && o_res.done_res))
        else $error("alive and done_res both set");

endmodule

bind life_automaton_generation_unit lag_checker u_lag_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .start  (start),
    .busy   (busy),
    .i_cmd  (i_cmd),
    .o_valid(o_valid),
    .o_res  (o_res)
);

// ===== tb/life_automaton_generation_unit_checker.sv =====
// ----------------------------------------------------------------------------
// life_automaton_generation_unit_checker
// watches the command and result channels, keeps its own copy of the life
// grid, predicts each result and compares it field by field in arrival order
// ----------------------------------------------------------------------------
module life_automaton_generation_unit_checker #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  lag_pkg::t_cmd i_cmd,
    input  logic          i_valid,
    input  lag_pkg::t_res i_res,
    output int            o_mismatch_cnt,
    output int            o_outstanding
);

    typedef struct {
        lag_pkg::t_cmd cmd;
        lag_pkg::t_res res;
    } t_cell_expect;

    bit           cells      [GRID_HEIGHT][GRID_WIDTH];
    bit           next_cells [GRID_HEIGHT][GRID_WIDTH];
    t_cell_expect pending_cell_results[$];
    t_cell_expect oldest;
    int           mismatches = 0;

    // one b3/s23 generation on the torus, built from the old grid only
    function automatic void advance_generation();
        int nb;
        for (int y = 0; y < GRID_HEIGHT; y++) begin
            for (int x = 0; x < GRID_WIDTH; x++) begin
                nb = 0;
                for (int dy = -1; dy <= 1; dy++) begin
                    for (int dx = -1; dx <= 1; dx++) begin
                        if (dy != 0 || dx != 0) begin
                            nb += cells[(y + dy + GRID_HEIGHT) % GRID_HEIGHT]
                                       [(x + dx + GRID_WIDTH) % GRID_WIDTH];
                        end
                    end
                end
                next_cells[y][x] = (nb == 3) || (cells[y][x] && nb == 2);
            end
        end
        cells = next_cells;
    endfunction

    function automatic lag_pkg::t_res apply_cmd(lag_pkg::t_cmd c);
        lag_pkg::t_res r;
        bit            in_grid;
        r       = '0;
        in_grid = (int'(c.col) < GRID_WIDTH) && (int'(c.row) < GRID_HEIGHT);
        case (c.op)
            lag_pkg::OP_WRITE: begin
                if (in_grid) cells[c.row][c.col] = c.cell_in;
            end
            lag_pkg::OP_STEP: begin
                advance_generation();
                r.done_res = 1'b1;
            end
            lag_pkg::OP_READ: begin
                if (in_grid) r.alive = cells[c.row][c.col];
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int y = 0; y < GRID_HEIGHT; y++) begin
                for (int x = 0; x < GRID_WIDTH; x++) begin
                    cells[y][x] = 1'b0;
                end
            end
            pending_cell_results.delete();
        end else begin
            // results first: a command never returns in its own transfer cycle
            if (i_valid !== 1'b0) begin
                if (pending_cell_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result with nothing pending: alive %b done_res %b",
                                 $realtime, i_res.alive, i_res.done_res);
                    end
                end else begin
                    oldest = pending_cell_results.pop_front();
                    if (i_res.alive !== oldest.res.alive ||
                        i_res.done_res !== oldest.res.done_res) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"%0t: op %0d col %0d row %0d: expected alive %b ",
                                      "done_res %b, got alive %b done_res %b"},
                                     $realtime, oldest.cmd.op, oldest.cmd.col,
                                     oldest.cmd.row, oldest.res.alive, oldest.res.done_res,
                                     i_res.alive, i_res.done_res);
                        end
                    end
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                oldest.cmd = i_cmd;
                oldest.res = apply_cmd(i_cmd);
                pending_cell_results.push_back(oldest);
            end
        end
        o_outstanding  <= pending_cell_results.size();
        o_mismatch_cnt <= mismatches;
    end

endmodule

// ===== tb/life_automaton_generation_unit_tb.sv =====
// ----------------------------------------------------------------------------
// life_automaton_generation_unit_tb
// drives cell writes, reads and generation steps into the life unit and lets
// the checker compare every result against its own grid; directed patterns
// across the wrapped edges first, then windowed random traffic
// ----------------------------------------------------------------------------
module life_automaton_generation_unit_tb;

    localparam int         GRID_W       = 64;
    localparam int         GRID_H       = 64;
    // op code the block ignores
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    // drain time with room for two generation steps
    localparam int         DRAIN_CYCLES = 2 * (GRID_H + 4);
    localparam int         RANDOM_ITEMS = 110;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    lag_pkg::t_cmd i_cmd;
    logic          o_valid;
    lag_pkg::t_res o_res;

    int            mismatch_cnt;
    int            outstanding;
    // when set the sender issues commands back to back
    bit            back_to_back = 1'b0;

    always #5 i_clk = ~i_clk;

    life_automaton_generation_unit #(
        .GRID_WIDTH  (GRID_W),
        .GRID_HEIGHT (GRID_H)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    life_automaton_generation_unit_checker #(
        .GRID_WIDTH  (GRID_W),
        .GRID_HEIGHT (GRID_H)
    ) checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_cmd          (i_cmd),
        .i_valid        (o_valid),
        .i_res          (o_res),
        .o_mismatch_cnt (mismatch_cnt),
        .o_outstanding  (outstanding)
    );

    // idle time after a transfer: mostly none or short, now and then long
    task automatic sender_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (back_to_back || r < 45) begin
            n = 0;
        end else if (r < 80) begin
            n = $urandom_range(1, 3);
        end else if (r < 95) begin
            n = $urandom_range(4, 12);
        end else begin
            n = $urandom_range(20, 80);
        end
        // with no gap start stays high and the next command follows directly
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // present one command and hold it until the transfer happens
    task automatic send_cmd(input logic [1:0] op, input int col, input int row,
                            input logic val);
        lag_pkg::t_cmd c;
        c.op      = op;
        c.col     = col[lag_pkg::FIELD_W-1:0];
        c.row     = row[lag_pkg::FIELD_W-1:0];
        c.cell_in = val;
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        // busy is still the pre-edge value here, so this is the transfer test
        while (busy !== 1'b0) @(posedge i_clk);
        sender_gap();
    endtask

    // hold off the sender until every pending result has come back
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    initial begin
        int         counted;
        int         seg;
        int         win_col;
        int         win_row;
        int         r;
        int         col;
        int         row;
        logic [1:0] op;
        logic       val;

        start   <= 1'b0;
        i_cmd   <= '0;
        i_rst_n <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part ----
        // grid is dead after reset
        send_cmd(lag_pkg::OP_READ, 0, 0, 1'b0);
        // corner cells, lowest and highest address
        send_cmd(lag_pkg::OP_WRITE, 0, 0, 1'b1);
        send_cmd(lag_pkg::OP_WRITE, 63, 63, 1'b1);
        send_cmd(lag_pkg::OP_READ, 0, 0, 1'b0);
        send_cmd(lag_pkg::OP_READ, 63, 63, 1'b0);
        // unused op with every field bit set must leave the grid alone
        send_cmd(OP_UNUSED, 63, 63, 1'b1);
        send_cmd(lag_pkg::OP_READ, 63, 63, 1'b1);
        send_cmd(lag_pkg::OP_WRITE, 63, 63, 1'b0);
        // horizontal blinker straddling the left/right wrap on row 0
        send_cmd(lag_pkg::OP_WRITE, 63, 0, 1'b1);
        send_cmd(lag_pkg::OP_WRITE, 1, 0, 1'b1);
        // step fields other than op are don't care
        send_cmd(lag_pkg::OP_STEP, 63, 63, 1'b1);
        // now vertical through column 0, straddling the top/bottom wrap
        send_cmd(lag_pkg::OP_READ, 0, 63, 1'b0);
        send_cmd(lag_pkg::OP_READ, 0, 1, 1'b0);
        send_cmd(lag_pkg::OP_READ, 63, 0, 1'b0);
        send_cmd(lag_pkg::OP_STEP, 0, 0, 1'b0);
        send_cmd(lag_pkg::OP_READ, 63, 0, 1'b0);
        // a lone cell dies of underpopulation
        send_cmd(lag_pkg::OP_WRITE, 32, 32, 1'b1);
        send_cmd(lag_pkg::OP_STEP, 17, 46, 1'b0);
        send_cmd(lag_pkg::OP_READ, 32, 32, 1'b0);
        // overwrite a live cell with dead, read it and its mirror address
        send_cmd(lag_pkg::OP_WRITE, 42, 21, 1'b1);
        send_cmd(lag_pkg::OP_WRITE, 42, 21, 1'b0);
        send_cmd(lag_pkg::OP_READ, 42, 21, 1'b1);
        send_cmd(lag_pkg::OP_READ, 21, 42, 1'b0);

        // quiet point between the directed and the random part
        wait_for_results();

        // ---- random part ----
        // writes and reads cluster in an 8x8 window so patterns interact and
        // evolve; the window moves every 12 to 24 items, edges included
        counted = 0;
        seg     = 0;
        win_col = 0;
        win_row = 0;
        while (counted < RANDOM_ITEMS) begin
            if (seg == 0) begin
                seg          = $urandom_range(12, 24);
                win_col      = $urandom_range(0, GRID_W - 1);
                win_row      = $urandom_range(0, GRID_H - 1);
                back_to_back = ($urandom_range(0, 3) == 0);
            end
            seg--;
            if ($urandom_range(0, 4) != 0) begin
                col = (win_col + $urandom_range(0, 7)) % GRID_W;
                row = (win_row + $urandom_range(0, 7)) % GRID_H;
            end else begin
                col = $urandom_range(0, 63);
                row = $urandom_range(0, 63);
            end
            val = 1'($urandom_range(0, 1));
            r   = $urandom_range(0, 99);
            if (r < 45) begin
                op  = lag_pkg::OP_WRITE;
                // lean toward live cells so the window fills up
                val = ($urandom_range(0, 9) < 6);
            end else if (r < 75) begin
                op = lag_pkg::OP_READ;
            end else if (r < 92) begin
                op = lag_pkg::OP_STEP;
            end else begin
                op = OP_UNUSED;
            end
            send_cmd(op, col, row, val);
            if (op != OP_UNUSED) begin
                counted++;
                // sender holds off once more midway until the unit is empty
                if (counted == RANDOM_ITEMS / 2) wait_for_results();
            end
        end

        // ---- end of run ----
        back_to_back = 1'b0;
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && outstanding == 0) begin
            $display("PASS life_automaton_generation_unit");
        end else begin
            $display("FAIL life_automaton_generation_unit");
        end
        $finish;
    end

    // hard stop well past the slowest legal run
    initial begin
        #2000000;
        $display("FAIL life_automaton_generation_unit");
        $finish;
    end

endmodule

// ===== files.f =====
src/lag_pkg.sv
src/lag_row_ram.sv
src/lag_row_rule.sv
src/life_automaton_generation_unit.sv
src/lag_checker.sv
tb/life_automaton_generation_unit_checker.sv
tb/life_automaton_generation_unit_tb.sv
